/* hw/rtl/sorted_priority_queue_defines.svh */
// assertion helpers for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SPQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("%m: label failed");
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("%m: label failed");
`endif

/* hw/rtl/spq_pkg.sv */
package spq_pkg;
	localparam int DEPTH_DEF = 16;
	localparam int KEY_W_DEF = 16;
	localparam int PAY_W_DEF = 16;

	typedef enum logic [2:0] {
		OP_OFFER = 3'd0, OP_PEEK = 3'd1, OP_POLL = 3'd2,
		OP_READ = 3'd3, OP_RMATCH = 3'd4, OP_RMAT = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0, ST_NONE = 2'd1, ST_FULL = 2'd2
	} status_t;

	localparam logic [0:0] REG_ORDER = 1'b0;
	// byte address of the order register
	localparam logic [1:0] ADDR_ORDER = 2'({REG_ORDER, 2'b00});

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] key;
		logic [15:0] payload;
		logic [3:0]  position;
	} req_t;

	typedef struct packed {
		logic [15:0] result_payload;
		logic [3:0]  result_position;
		logic [4:0]  removed_count;
		logic [4:0]  occupancy;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [1:0] {
		BK_IDLE, BK_SCAN, BK_DONE
	} bk_state_t;
endpackage

/* hw/rtl/spq_front.sv */
// accepts requests into a two-entry queue
module spq_front import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	input  logic pop,
	output logic avail,
	output req_t head
);
	req_t        buf_q [2];
	logic        rd_q, wr_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign busy  = cnt_q == 2'd2;
	assign push  = start && !busy;
	assign avail = cnt_q != 2'd0;
	assign head  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* hw/rtl/spq_back.sv */
// executes one operation on the entry row; remove-match compacts one entry a cycle
module spq_back import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int KEY_W = KEY_W_DEF,
	parameter int PAY_W = PAY_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic order_largest_first,
	input  logic avail,
	input  req_t head,
	output logic pop,
	output logic done,
	output rsp_t result
);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [KEY_W-1:0] key_q [DEPTH];
	logic [PAY_W-1:0] pay_q [DEPTH];
	logic [CW-1:0]    cnt_q;
	bk_state_t        state_q, state_d;
	logic [CW-1:0]    rd_q, wr_q, rm_q;
	logic [PAY_W-1:0] match_q;
	rsp_t             res_q;
	rsp_t             res_d;
	logic             done_q;

	logic [KEY_W-1:0] in_key;
	logic [PAY_W-1:0] in_pay;
	logic [DEPTH-1:0] behind;
	logic [CW-1:0]    ins_pos;
	logic [CW-1:0]    at;
	logic             at_ok;
	op_t              op;

	assign op     = op_t'(head.opcode);
	assign in_key = KEY_W'(head.key);
	assign in_pay = PAY_W'(head.payload);
	assign done   = done_q;
	assign result = res_q;

	// entries that the new key goes in front of
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			behind[i] = (CW'(i) < cnt_q) &&
				(order_largest_first ? key_q[i] < in_key : key_q[i] > in_key);
		end
		ins_pos = cnt_q;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (behind[i]) ins_pos = CW'(i);
		end
	end

	always_comb begin
		at = (op == OP_POLL || op == OP_PEEK) ? '0 : CW'(head.position);
		at_ok = at < cnt_q;
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			BK_IDLE: if (avail) begin
				pop = 1'b1;
				state_d = (op == OP_RMATCH) ? BK_SCAN : BK_DONE;
			end
			BK_SCAN: if (rd_q >= cnt_q) state_d = BK_DONE;
			BK_DONE: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		res_d = res_q;
		if (state_q == BK_IDLE && avail) begin
			res_d = '0;
			res_d.occupancy = 5'(cnt_q);
			case (op)
				OP_OFFER: begin
					if (cnt_q < CW'(DEPTH)) begin
						res_d.result_position = 4'(ins_pos);
						res_d.occupancy = 5'(cnt_q + 1'b1);
					end else begin
						res_d.status = ST_FULL;
					end
				end
				OP_PEEK, OP_POLL, OP_READ, OP_RMAT: begin
					if (at_ok) begin
						res_d.result_payload = 16'(pay_q[at[IW-1:0]]);
						if (op == OP_POLL || op == OP_RMAT)
							res_d.occupancy = 5'(cnt_q - 1'b1);
					end else begin
						res_d.status = ST_NONE;
					end
				end
				default: ;
			endcase
		end else if (state_q == BK_SCAN && rd_q >= cnt_q) begin
			res_d.removed_count = 5'(rm_q);
			res_d.occupancy = 5'(wr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == BK_IDLE && avail && op != OP_RMATCH) ||
				(state_q == BK_SCAN && rd_q >= cnt_q);
			if (state_q == BK_IDLE && avail) begin
				case (op)
					OP_OFFER: if (cnt_q < CW'(DEPTH)) cnt_q <= cnt_q + 1'b1;
					OP_POLL, OP_RMAT: if (at_ok) cnt_q <= cnt_q - 1'b1;
					default: ;
				endcase
			end
			if (state_q == BK_SCAN && rd_q >= cnt_q) begin
				cnt_q <= wr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == BK_IDLE && avail) begin
			rd_q <= '0;
			wr_q <= '0;
			rm_q <= '0;
			match_q <= in_pay;
			case (op)
				OP_OFFER: begin
					if (cnt_q < CW'(DEPTH)) begin
						for (int i = 0; i < DEPTH; i++) begin
							if (CW'(i) == ins_pos) begin
								key_q[i] <= in_key;
								pay_q[i] <= in_pay;
							end else if (CW'(i) > ins_pos && i > 0) begin
								key_q[i] <= key_q[i-1];
								pay_q[i] <= pay_q[i-1];
							end
						end
					end
				end
				OP_POLL, OP_RMAT: begin
					if (at_ok) begin
						for (int i = 0; i < DEPTH - 1; i++) begin
							if (CW'(i) >= at) begin
								key_q[i] <= key_q[i+1];
								pay_q[i] <= pay_q[i+1];
							end
						end
					end
				end
				default: ;
			endcase
		end
		if (state_q == BK_SCAN) begin
			if (rd_q < cnt_q) begin
				if (pay_q[rd_q[IW-1:0]] == match_q) begin
					rm_q <= rm_q + 1'b1;
				end else begin
					key_q[wr_q[IW-1:0]] <= key_q[rd_q[IW-1:0]];
					pay_q[wr_q[IW-1:0]] <= pay_q[rd_q[IW-1:0]];
					wr_q <= wr_q + 1'b1;
				end
				rd_q <= rd_q + 1'b1;
			end
		end
	end
endmodule

/* hw/rtl/sorted_priority_queue.sv */
// Sorted priority queue: offer, peek, poll, read at, remove matching, remove at.
// A request is held in the two-entry request queue until the back end takes it in BK_IDLE;
// the strobe is registered, and the back end returns through BK_DONE to BK_IDLE before
// taking another request; remove matching first passes BK_SCAN over every occupied entry.
// A two-entry request queue hides bursts. Receiver cannot stall.
// Reset clears occupancy, order register and queues; entry storage is not cleared.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int KEY_W = KEY_W_DEF,
	parameter int PAY_W = PAY_W_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        strobe,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic order_q;
	logic avail, pop;
	req_t head;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_ORDER) ? {31'b0, order_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) order_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == ADDR_ORDER) order_q <= pwdata[0];
	end

	spq_front u_front (
		.clk, .arst_n, .start, .req, .busy, .pop, .avail, .head
	);

	spq_back #(.DEPTH(DEPTH), .KEY_W(KEY_W), .PAY_W(PAY_W)) u_back (
		.clk, .arst_n, .order_largest_first(order_q), .avail, .head, .pop,
		.done(strobe), .result(rsp)
	);
endmodule

/* hw/rtl/spq_checker.sv */
`include "sorted_priority_queue_defines.svh"
module spq_checker import spq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic strobe,
	input rsp_t rsp
);
	`SPQ_ASSERT_IMP(a_occ_range, strobe, rsp.occupancy <= 5'd16)
	`SPQ_ASSERT_IMP(a_full_pos, strobe && rsp.status == ST_FULL, rsp.result_position == 4'd0)
	`SPQ_ASSERT_NEXT(a_strobe_gap, strobe, !strobe)
	`SPQ_ASSERT_IMP(a_none_pay, strobe && rsp.status == ST_NONE, rsp.result_payload == 16'd0)
endmodule

bind sorted_priority_queue spq_checker u_checker (
	.clk(clk), .arst_n(arst_n), .strobe(strobe), .rsp(rsp)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import spq_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        strobe;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sorted_priority_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.strobe(strobe), .rsp(rsp), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// shadow of the queue contents
	logic [15:0] q_keys[16];
	logic [15:0] q_pays[16];
	int          q_count;
	logic        largest_first;

	req_t  pending_reqs[$];
	int    pending_gaps[$];
	rsp_t  expected_rsps[$];
	int    mismatches;
	int    gap_left;
	bit    stim_done;
	bit    cfg_req;
	logic  cfg_value;
	bit    cfg_done;
	int    cfg_phase;

	function automatic rsp_t queue_apply(req_t r);
		rsp_t o;
		int i, w;
		o = '0;
		case (r.opcode)
			OP_OFFER: begin
				if (q_count >= 16) begin
					o.status = ST_FULL;
				end else begin
					for (i = 0; i < q_count; i++)
						if (largest_first ? (q_keys[i] < r.key) : (q_keys[i] > r.key))
							break;
					for (w = q_count; w > i; w--) begin
						q_keys[w] = q_keys[w-1];
						q_pays[w] = q_pays[w-1];
					end
					q_keys[i] = r.key;
					q_pays[i] = r.payload;
					q_count++;
					o.result_position = i[3:0];
				end
			end
			OP_PEEK, OP_POLL, OP_READ, OP_RMAT: begin
				int p;
				p = (r.opcode == OP_READ || r.opcode == OP_RMAT) ? int'(r.position) : 0;
				if (p >= q_count) begin
					o.status = ST_NONE;
				end else begin
					o.result_payload = q_pays[p];
					if (r.opcode == OP_POLL || r.opcode == OP_RMAT) begin
						for (i = p; i + 1 < q_count; i++) begin
							q_keys[i] = q_keys[i+1];
							q_pays[i] = q_pays[i+1];
						end
						q_count--;
					end
				end
			end
			OP_RMATCH: begin
				w = 0;
				for (i = 0; i < q_count; i++) begin
					if (q_pays[i] == r.payload) begin
						o.removed_count++;
					end else begin
						q_keys[w] = q_keys[i];
						q_pays[w] = q_pays[i];
						w++;
					end
				end
				q_count = w;
			end
			default: ;
		endcase
		o.occupancy = q_count[4:0];
		return o;
	endfunction

	function automatic req_t make_req(logic [2:0] op, logic [15:0] k, logic [15:0] p,
			logic [3:0] pos);
		req_t r;
		r.opcode = op;
		r.key = k;
		r.payload = p;
		r.position = pos;
		return r;
	endfunction

	// small pool of payloads so remove matching finds hits
	function automatic req_t rand_req();
		req_t r;
		int sel;
		sel = $urandom_range(0, 99);
		r.key = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
		r.payload = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
		r.position = 4'($urandom);
		if (sel < 40)      r.opcode = OP_OFFER;
		else if (sel < 50) r.opcode = OP_PEEK;
		else if (sel < 62) r.opcode = OP_POLL;
		else if (sel < 74) r.opcode = OP_READ;
		else if (sel < 84) r.opcode = OP_RMATCH;
		else if (sel < 96) r.opcode = OP_RMAT;
		else               r.opcode = 3'($urandom_range(6, 7));
		return r;
	endfunction

	function automatic int rand_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
	endfunction

	// driver: requests and register writes, all at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable) begin
				psel <= 1'b0;
				penable <= 1'b0;
				pwrite <= 1'b0;
				cfg_done <= 1'b1;
			end else if (psel) begin
				penable <= 1'b1;
			end else if (cfg_req && !cfg_done && !start) begin
				psel <= 1'b1;
				pwrite <= 1'b1;
				paddr <= ADDR_ORDER;
				pwdata <= {31'd0, cfg_value};
			end else if (start && !busy) begin
				expected_rsps.push_back(queue_apply(req));
				if (pending_reqs.size() > 0 && pending_gaps[0] == 0 && !cfg_req) begin
					req <= pending_reqs.pop_front();
					void'(pending_gaps.pop_front());
				end else begin
					start <= 1'b0;
					gap_left <= (pending_gaps.size() > 0) ? pending_gaps[0] : 0;
				end
			end else if (!start && !cfg_req && pending_reqs.size() > 0) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else begin
					req <= pending_reqs.pop_front();
					void'(pending_gaps.pop_front());
					start <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", rsp);
			end else begin
				rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", e, rsp);
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_order(logic v);
		wait_drained();
		cfg_value = v;
		cfg_done = 1'b0;
		cfg_req = 1'b1;
		while (!cfg_done) @(posedge clk);
		cfg_req = 1'b0;
		largest_first = v;
	endtask

	task automatic push(req_t r, int g);
		pending_reqs.push_back(r);
		pending_gaps.push_back(g);
	endtask

	initial begin
		int i, n;
		q_count = 0;
		largest_first = 1'b0;
		mismatches = 0;
		gap_left = 0;
		cfg_req = 1'b0;
		cfg_done = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty cases, extremes, fill to full, bad positions
		push(make_req(OP_PEEK, 16'h0, 16'h0, 4'h0), 0);
		push(make_req(OP_POLL, 16'hffff, 16'hffff, 4'hf), 0);
		push(make_req(OP_READ, 16'h0, 16'h0, 4'h0), 0);
		push(make_req(OP_RMAT, 16'h0, 16'h0, 4'hf), 0);
		push(make_req(OP_RMATCH, 16'h0, 16'h1234, 4'h0), 0);
		push(make_req(3'd6, 16'hffff, 16'hffff, 4'hf), 0);
		push(make_req(3'd7, 16'h0, 16'h0, 4'h0), 0);
		for (i = 0; i < 17; i++)
			push(make_req(OP_OFFER, (i % 3 == 0) ? 16'hffff : 16'(i % 4), 16'(i % 3), 4'h0), 0);
		wait_drained();
		push(make_req(OP_READ, 16'h0, 16'h0, 4'hf), 1);
		push(make_req(OP_RMAT, 16'h0, 16'h0, 4'hf), 2);
		push(make_req(OP_RMATCH, 16'h0, 16'h0001, 4'h0), 0);
		push(make_req(OP_READ, 16'h0, 16'h0, 4'hf), 0);
		for (i = 0; i < 16; i++)
			push(make_req(OP_POLL, 16'h0, 16'h0, 4'h0), 0);
		write_order(1'b1);
		for (n = 0; n < 1700; n++) begin
			if (n == 600) write_order(1'b0);
			if (n == 1200) write_order(1'b1);
			if (n == 900) wait_drained();
			push(rand_req(), rand_gap());
		end
		wait_drained();
		write_order(1'b0);
		for (n = 0; n < 40; n++) push(rand_req(), rand_gap());
		wait_drained();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
